### rtl/core/q24_pkg.sv
// ----------------------------------------------------------------------------
// q24_pkg: shared types and constants of the Q24.8 ALU
// Opcodes, fixed widths and the payload that travels down the pipeline.
// ----------------------------------------------------------------------------
package q24_pkg;

  localparam int unsigned FracBits  = 8;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned NumBits   = WordBits + FracBits;
  localparam int unsigned DivStages = 10;
  localparam int unsigned DivStep   = NumBits / DivStages;

  localparam logic [4:0] OpAdd  = 5'd0;
  localparam logic [4:0] OpSub  = 5'd1;
  localparam logic [4:0] OpMul  = 5'd2;
  localparam logic [4:0] OpDiv  = 5'd3;
  localparam logic [4:0] OpGt   = 5'd4;
  localparam logic [4:0] OpLt   = 5'd5;
  localparam logic [4:0] OpGe   = 5'd6;
  localparam logic [4:0] OpLe   = 5'd7;
  localparam logic [4:0] OpEq   = 5'd8;
  localparam logic [4:0] OpNe   = 5'd9;
  localparam logic [4:0] OpMin  = 5'd10;
  localparam logic [4:0] OpMax  = 5'd11;
  localparam logic [4:0] OpInc  = 5'd12;
  localparam logic [4:0] OpDec  = 5'd13;
  localparam logic [4:0] OpItoF = 5'd14;
  localparam logic [4:0] OpFtoI = 5'd15;
  localparam logic [4:0] OpFlIn = 5'd16;
  localparam logic [4:0] OpFlOu = 5'd17;

  // what the front stage hands to the back end
  typedef struct packed {
    logic [31:0] res;     // finished result of the simple ops
    logic        cmp;
    logic        err;
    logic        div_en;  // result comes from the divider
    logic        dneg;    // quotient sign
    logic        fl_en;   // result is fixed->float
    logic        fsign;
    logic [31:0] fmag;
    logic [4:0]  flz;
  } pay_t;

endpackage

### rtl/core/q24_pre.sv
// ----------------------------------------------------------------------------
// q24_pre: front stage
// Decodes the opcode, computes the simple ops and prepares divide and
// fixed->float operands.
// ----------------------------------------------------------------------------
module q24_pre (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic [4:0]               opcode_i,
  input  logic signed [31:0]       operand_a_i,
  input  logic signed [31:0]       operand_b_i,
  output logic                     vld_o,
  output q24_pkg::pay_t            pay_o,
  output logic [q24_pkg::NumBits-1:0] num_o,
  output logic [31:0]              den_o
);
  import q24_pkg::*;

  logic                vld_q;
  pay_t                pay_d, pay_q;
  logic [NumBits-1:0]  num_d, num_q;
  logic [31:0]         den_d, den_q;

  logic [31:0]         abs_a, abs_b;
  logic signed [63:0]  prod;
  logic                gt, eq;
  logic [4:0]          lz;
  // float to fixed
  logic [7:0]          fex;
  logic [23:0]         fm;
  logic signed [9:0]   fk;
  logic [8:0]          fsh;
  logic [40:0]         fmag;
  logic [40:0]         fwide;
  logic                fsticky;
  logic [31:0]         fres;
  logic                ferr;

  always_comb begin
    abs_a = operand_a_i[31] ? 32'(-operand_a_i) : 32'(operand_a_i);
    abs_b = operand_b_i[31] ? 32'(-operand_b_i) : 32'(operand_b_i);
    prod  = operand_a_i * operand_b_i;
    gt    = operand_a_i > operand_b_i;
    eq    = operand_a_i == operand_b_i;

    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (abs_a[i]) lz = 5'(31 - i);
    end

    fex     = operand_a_i[30:23];
    fm      = {fex != 8'd0, operand_a_i[22:0]};
    fk      = $signed({2'b00, (fex == 8'd0) ? 8'd1 : fex}) - 10'sd142;
    fsh     = 9'(-fk);
    fwide   = {17'd0, fm};
    fsticky = |(fwide & ~({41{1'b1}} << fsh[5:0]));
    if (fk >= 0) begin
      if (fk >= 10'sd9) fmag = 41'h100_0000_0000;
      else              fmag = fwide << fk[3:0];
    end else if (fsh >= 9'd40) begin
      fmag = {40'd0, fm != 24'd0};
    end else begin
      fmag = (fwide >> fsh[5:0]) + {40'd0, fsticky};
    end
    ferr = 1'b0;
    if (fex == 8'hFF) begin
      ferr = 1'b1;
      if (operand_a_i[22:0] != 23'd0) fres = 32'd0;
      else fres = operand_a_i[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (operand_a_i[31]) begin
      if (fmag > 41'h0_8000_0000) begin
        ferr = 1'b1;
        fres = 32'h8000_0000;
      end else begin
        fres = 32'(-fmag);
      end
    end else begin
      if (fmag > 41'h0_7FFF_FFFF) begin
        ferr = 1'b1;
        fres = 32'h7FFF_FFFF;
      end else begin
        fres = fmag[31:0];
      end
    end

    pay_d        = '0;
    pay_d.dneg   = operand_a_i[31] ^ operand_b_i[31];
    pay_d.fsign  = operand_a_i[31];
    pay_d.fmag   = abs_a;
    pay_d.flz    = lz;
    num_d        = {abs_a, {FracBits{1'b0}}};
    den_d        = abs_b;
    unique case (opcode_i)
      OpAdd: pay_d.res = 32'(operand_a_i + operand_b_i);
      OpSub: pay_d.res = 32'(operand_a_i - operand_b_i);
      OpMul: pay_d.res = prod[FracBits +: WordBits];
      OpDiv: begin
        if (operand_b_i == 32'sd0) pay_d.err = 1'b1;
        else pay_d.div_en = 1'b1;
      end
      OpGt:  pay_d.cmp = gt;
      OpLt:  pay_d.cmp = !gt && !eq;
      OpGe:  pay_d.cmp = gt || eq;
      OpLe:  pay_d.cmp = !gt;
      OpEq:  pay_d.cmp = eq;
      OpNe:  pay_d.cmp = !eq;
      OpMin: pay_d.res = gt ? operand_b_i : operand_a_i;
      OpMax: pay_d.res = gt ? operand_a_i : operand_b_i;
      OpInc: pay_d.res = 32'(operand_a_i + 32'sd1);
      OpDec: pay_d.res = 32'(operand_a_i - 32'sd1);
      OpItoF: begin
        if (operand_a_i[31:23] != {9{operand_a_i[31]}}) begin
          pay_d.err = 1'b1;
          pay_d.res = operand_a_i[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          pay_d.res = {operand_a_i[23:0], {FracBits{1'b0}}};
        end
      end
      OpFtoI: pay_d.res = 32'(operand_a_i >>> FracBits);
      OpFlIn: begin
        pay_d.res = fres;
        pay_d.err = ferr;
      end
      OpFlOu: pay_d.fl_en = abs_a != 32'd0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  assign vld_o = vld_q;
  assign pay_o = pay_q;
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

### rtl/core/q24_div.sv
// ----------------------------------------------------------------------------
// q24_div: pipelined restoring divider
// Unsigned 40-by-32 division, four quotient bits per stage; side payload
// travels along.
// ----------------------------------------------------------------------------
module q24_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  q24_pkg::pay_t               pay_i,
  input  logic [q24_pkg::NumBits-1:0] num_i,
  input  logic [31:0]                 den_i,
  output logic                        vld_o,
  output q24_pkg::pay_t               pay_o,
  output logic [q24_pkg::NumBits-1:0] quo_o
);
  import q24_pkg::*;

  // index 0 is the stage input, index s+1 the register after stage s
  logic               vld_w [DivStages+1];
  pay_t               pay_w [DivStages+1];
  logic [NumBits-1:0] nq_w  [DivStages+1];
  logic [31:0]        rem_w [DivStages+1];
  logic [31:0]        den_w [DivStages+1];

  assign vld_w[0] = vld_i;
  assign pay_w[0] = pay_i;
  assign nq_w[0]  = num_i;
  assign rem_w[0] = '0;
  assign den_w[0] = den_i;

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic               vld_q;
    pay_t               pay_q;
    logic [NumBits-1:0] nq_d, nq_q;
    logic [31:0]        rem_d, rem_q;
    logic [31:0]        den_q;

    always_comb begin
      logic [32:0] t;
      nq_d  = nq_w[s];
      rem_d = rem_w[s];
      for (int i = 0; i < DivStep; i++) begin
        t = {rem_d, nq_d[NumBits-1]};
        if (t >= {1'b0, den_w[s]}) begin
          rem_d = 32'(t - {1'b0, den_w[s]});
          nq_d  = {nq_d[NumBits-2:0], 1'b1};
        end else begin
          rem_d = t[31:0];
          nq_d  = {nq_d[NumBits-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pay_q <= pay_w[s];
        nq_q  <= nq_d;
        rem_q <= rem_d;
        den_q <= den_w[s];
      end
    end

    assign vld_w[s+1] = vld_q;
    assign pay_w[s+1] = pay_q;
    assign nq_w[s+1]  = nq_q;
    assign rem_w[s+1] = rem_q;
    assign den_w[s+1] = den_q;
  end

  assign vld_o = vld_w[DivStages];
  assign pay_o = pay_w[DivStages];
  assign quo_o = nq_w[DivStages];

endmodule

### rtl/core/q24_post.sv
// ----------------------------------------------------------------------------
// q24_post: back stage
// Signs and saturates the quotient, rounds fixed->float, output register.
// ----------------------------------------------------------------------------
module q24_post (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  q24_pkg::pay_t               pay_i,
  input  logic [q24_pkg::NumBits-1:0] quo_i,
  output logic                        vld_o,
  output logic signed [31:0]          result_value_o,
  output logic                        compare_true_o,
  output logic                        error_flag_o
);
  import q24_pkg::*;

  logic        vld_q;
  logic [31:0] res_d, res_q;
  logic        cmp_q;
  logic        err_d, err_q;
  logic [31:0] norm;
  logic [24:0] mant;
  logic        rnd;
  logic [7:0]  expb;

  always_comb begin
    norm = pay_i.fmag << pay_i.flz;
    rnd  = norm[7] && ((|norm[6:0]) || norm[8]);
    mant = {1'b0, norm[31:8]} + {24'd0, rnd};
    // exponent is (31 - lz) + 127 - FracBits
    expb = 8'(8'd158 - FracBits - {3'd0, pay_i.flz});
    if (mant[24]) begin
      mant = mant >> 1;
      expb = expb + 8'd1;
    end

    res_d = pay_i.res;
    err_d = pay_i.err;
    if (pay_i.div_en) begin
      if (pay_i.dneg) begin
        if (quo_i > NumBits'(33'h0_8000_0000)) begin
          res_d = 32'h8000_0000;
          err_d = 1'b1;
        end else begin
          res_d = 32'(-quo_i);
        end
      end else begin
        if (quo_i > NumBits'(33'h0_7FFF_FFFF)) begin
          res_d = 32'h7FFF_FFFF;
          err_d = 1'b1;
        end else begin
          res_d = quo_i[31:0];
        end
      end
    end else if (pay_i.fl_en) begin
      res_d = {pay_i.fsign, expb, mant[22:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      cmp_q <= pay_i.cmp;
      err_q <= err_d;
    end
  end

  assign vld_o          = vld_q;
  assign result_value_o = res_q;
  assign compare_true_o = cmp_q;
  assign error_flag_o   = err_q;

endmodule

### rtl/core/q24_8_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu: pipelined Q24.8 arithmetic unit
// Every opcode goes through the same 12-stage pipeline and gives one beat.
// ----------------------------------------------------------------------------
// One beat in and one beat out per cycle unless stalled. Every opcode passes
// the same stages: a front stage, ten divider stages of four quotient bits
// each, and an output register. The divider depth sets the latency. The whole
// pipeline holds while a finished beat sits in the output register with
// out_stall_i high; in_stall_o follows that condition.
module q24_8_fixed_point_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [4:0]         opcode_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic               compare_true_o,
  output logic               error_flag_o
);
  import q24_pkg::*;

  logic               en;
  logic               pre_vld, div_vld;
  pay_t               pre_pay, div_pay;
  logic [NumBits-1:0] pre_num, div_quo;
  logic [31:0]        pre_den;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  q24_pre u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .vld_i       (in_valid_i),
    .opcode_i    (opcode_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .vld_o       (pre_vld),
    .pay_o       (pre_pay),
    .num_o       (pre_num),
    .den_o       (pre_den)
  );

  q24_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pre_vld),
    .pay_i  (pre_pay),
    .num_i  (pre_num),
    .den_i  (pre_den),
    .vld_o  (div_vld),
    .pay_o  (div_pay),
    .quo_o  (div_quo)
  );

  q24_post u_post (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .vld_i          (div_vld),
    .pay_i          (div_pay),
    .quo_i          (div_quo),
    .vld_o          (out_valid_o),
    .result_value_o (result_value_o),
    .compare_true_o (compare_true_o),
    .error_flag_o   (error_flag_o)
  );

endmodule

### sim/tb_q24_8_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// tb_q24_8_fixed_point_alu: self-checking bench for the Q24.8 ALU
// Drives directed and random operations with random gaps and stalls and
// compares every output beat in order against a behavioral model.
// ----------------------------------------------------------------------------
module tb_q24_8_fixed_point_alu;
  import q24_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        err;
  } alu_res_t;

  // behavioral Q24.8 model
  function automatic logic [31:0] sat_word(input longint v, inout logic err);
    if (v > 64'sd2147483647) begin
      err = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      err = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] float_bits_to_q(input logic [31:0] u, inout logic err);
    logic [7:0]  ex;
    logic [63:0] m, mag;
    int          k, sh;
    ex = u[30:23];
    if (ex == 8'hFF) begin
      err = 1'b1;
      if (u[22:0] != 0) return 32'h0;
      return u[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    m = (ex != 0) ? {40'd0, 1'b1, u[22:0]} : {41'd0, u[22:0]};
    k = ((ex != 0) ? int'(ex) : 1) - 150 + 8;
    if (k >= 0) begin
      if (k >= 40) mag = (m != 0) ? (64'd1 << 40) : 64'd0;
      else mag = m << k;
    end else begin
      sh = -k;
      if (sh >= 40) mag = (m != 0) ? 64'd1 : 64'd0;
      else mag = (m >> sh) + (((m & ((64'd1 << sh) - 1)) != 0) ? 64'd1 : 64'd0);
    end
    if (u[31]) return sat_word(-longint'(mag), err);
    return sat_word(longint'(mag), err);
  endfunction

  function automatic logic [31:0] q_to_float_bits(input longint a);
    logic [63:0] mag, mant, rem, half;
    int          p, r;
    if (a == 0) return 32'h0;
    mag = (a < 0) ? -a : a;
    p = 0;
    while (p < 63 && (mag >> (p + 1)) != 0) p++;
    if (p <= 23) begin
      mant = mag << (23 - p);
    end else begin
      r = p - 23;
      rem = mag & ((64'd1 << r) - 1);
      half = 64'd1 << (r - 1);
      mant = mag >> r;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant >> 24) begin
        mant >>= 1;
        p++;
      end
    end
    return {(a < 0) ? 1'b1 : 1'b0, 8'(p + 127 - 8), mant[22:0]};
  endfunction

  function automatic alu_res_t alu_compute(input logic [4:0] op, input logic [31:0] ua,
                                           input logic [31:0] ub);
    alu_res_t    r;
    longint      a, b, q;
    logic [63:0] pr;
    logic        e;
    a = longint'(signed'(ua));
    b = longint'(signed'(ub));
    r = '0;
    e = 1'b0;
    case (op)
      OpAdd: r.value = ua + ub;
      OpSub: r.value = ua - ub;
      OpMul: begin
        pr = a * b;
        r.value = pr[39:8];
      end
      OpDiv: begin
        if (b == 0) e = 1'b1;
        else begin
          q = (a * 256) / b;
          r.value = sat_word(q, e);
        end
      end
      OpGt: r.cmp = a > b;
      OpLt: r.cmp = a < b;
      OpGe: r.cmp = a >= b;
      OpLe: r.cmp = a <= b;
      OpEq: r.cmp = a == b;
      OpNe: r.cmp = a != b;
      OpMin: r.value = (a > b) ? ub : ua;
      OpMax: r.value = (a > b) ? ua : ub;
      OpInc: r.value = ua + 32'd1;
      OpDec: r.value = ua - 32'd1;
      OpItoF: r.value = sat_word(a * 256, e);
      OpFtoI: r.value = {{8{ua[31]}}, ua[31:8]};
      OpFlIn: r.value = float_bits_to_q(ua, e);
      OpFlOu: r.value = q_to_float_bits(a);
      default: ;
    endcase
    r.err = e;
    return r;
  endfunction

  class alu_scoreboard;
    alu_res_t pending_q[$];
    int       n_bad;

    function void note_op(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b);
      pending_q.push_back(alu_compute(op, a, b));
    endfunction

    function void check_beat(input alu_res_t got);
      alu_res_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected output beat: value %h", got.value);
        n_bad++;
        return;
      end
      want = pending_q.pop_front();
      if (got.value !== want.value) begin
        $error("result_value: expected %h, actual %h", want.value, got.value);
        n_bad++;
      end
      if (got.cmp !== want.cmp) begin
        $error("compare_true: expected %b, actual %b", want.cmp, got.cmp);
        n_bad++;
      end
      if (got.err !== want.err) begin
        $error("error_flag: expected %b, actual %b", want.err, got.err);
        n_bad++;
      end
    endfunction
  endclass

  localparam int Latency  = 12;
  localparam int NumRand  = 1750;
  localparam int MaxCycle = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [4:0]         opcode_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic               compare_true_o;
  logic               error_flag_o;

  alu_scoreboard sb = new();
  int            cycle_cnt = 0;
  bit            hold_long = 1'b0;

  q24_8_fixed_point_alu i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MaxCycle) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: sample and check accepted beats, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_beat('{result_value_o, compare_true_o, error_flag_o});
  end

  initial begin
    int n;
    wait (rst_ni);
    forever begin
      if (hold_long) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        hold_long = 1'b0;
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      n = gap_len();
      out_stall_i <= (n != 0);
      if (n != 0) repeat (n - 1) @(posedge clk_i);
      if (n != 0) begin
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // one beat into the block; valid stays up across back-to-back beats
  task automatic send_op(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b);
    int n;
    n = gap_len();
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_op(op, a, b);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($urandom_range(0, 600)) - 32'd300;
      2: return {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, 8'($urandom)};
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_float();
    logic [7:0] ex;
    case ($urandom_range(0, 4))
      0: ex = 8'hFF;
      1: ex = 8'h00;
      2: ex = 8'($urandom_range(100, 165));
      default: ex = 8'($urandom_range(118, 150));
    endcase
    return {1'($urandom), ex, 23'($urandom) >> $urandom_range(0, 23)};
  endfunction

  initial begin
    logic [4:0]  op;
    logic [31:0] a, b;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every opcode, divide by zero and overflow,
    // float specials (inf, NaN, subnormal, negative tiny)
    send_op(OpAdd,  32'h7FFF_FFFF, 32'h0000_0001);
    send_op(OpSub,  32'h8000_0000, 32'h0000_0001);
    send_op(OpMul,  32'h8000_0000, 32'h8000_0000);
    send_op(OpMul,  32'hFFFF_FF00, 32'h0000_0180);
    send_op(OpDiv,  32'h0000_0500, 32'h0000_0000);
    send_op(OpDiv,  32'h7FFF_FFFF, 32'h0000_0001);
    send_op(OpDiv,  32'h8000_0000, 32'hFFFF_FFFF);
    send_op(OpDiv,  32'hFFFF_FD00, 32'h0000_0200);
    for (int i = OpGt; i <= OpMax; i++) send_op(5'(i), 32'h8000_0000, 32'h7FFF_FFFF);
    send_op(OpEq,   32'h1234_5678, 32'h1234_5678);
    send_op(OpInc,  32'h7FFF_FFFF, 32'h0);
    send_op(OpDec,  32'h8000_0000, 32'h0);
    send_op(OpItoF, 32'h0080_0000, 32'h0);
    send_op(OpItoF, 32'hFF7F_FFFF, 32'h0);
    send_op(OpFtoI, 32'hFFFF_FF01, 32'h0);
    send_op(OpFlIn, 32'h7F80_0000, 32'h0);
    send_op(OpFlIn, 32'h7FC0_0001, 32'h0);
    send_op(OpFlIn, 32'h8000_0001, 32'h0);
    send_op(OpFlOu, 32'h8000_0000, 32'h0);
    send_op(5'd31,  32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int i = 0; i < NumRand; i++) begin
      if (i == NumRand / 2) hold_long = 1'b1;
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31)) : 5'($urandom_range(0, 17));
      a = (op == OpFlIn) ? rand_float() : rand_word();
      b = ($urandom_range(0, 3) == 0) ? a : rand_word();
      send_op(op, a, b);
    end
    in_valid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency * 4) @(posedge clk_i);
    if (sb.n_bad == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
